FILE: src/vae_pkg.sv
// Shared constants and types for the voice allocator with expiry.
`default_nettype none

package vae_pkg;

  // Request codes carried on func
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PLAY  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  // Parameter defaults
  localparam int unsigned VOICES_DEF     = 16;
  localparam int unsigned SLOT_LIMIT_DEF = 256;

  // Fixed field widths
  localparam int unsigned FRAME_W   = 32;
  localparam int unsigned HANDLE_W  = 8;
  localparam int unsigned PITCH_W   = 16;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned VOUT_W    = 4;

  // Duration arithmetic constants
  localparam int unsigned BASE_RATE    = 22050;
  localparam int unsigned PITCH_SHIFT  = 12;      // pitch 4096 is the base rate
  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned FRAMES_PER_S = 60;
  localparam int unsigned FRAME_GCD    = 20;
  localparam int unsigned FRAME_MUL    = FRAMES_PER_S / FRAME_GCD;
  localparam int unsigned FRAME_DIV    = MS_PER_S / FRAME_GCD;
  localparam int unsigned EXTRA_FRAMES   = 10;
  localparam int unsigned DEFAULT_FRAMES = 120;
  localparam logic [FRAME_W-1:0] DUR_MAX = '1;

  // Datapath widths of the shared divider
  localparam int unsigned PROD_W = PITCH_W + 15;            // pitch * 22050
  localparam int unsigned RATE_W = PROD_W - PITCH_SHIFT;    // rate in Hz
  localparam int unsigned NUM_W  = SAMPLE_W + 10;           // samples * 1000
  localparam int unsigned DIV_W  = NUM_W;                   // ms quotient bits
  localparam int unsigned DCNT_W = $clog2(DIV_W);

  // Scale ms to frames as (ms * RECIP) >> RECIP_SHIFT, exact for every ms below 2^32
  localparam int unsigned MS_W        = 32;                 // a nonzero rate is at least 5
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned RECIP_W     = 34;
  localparam int unsigned RECIP_LO_W  = 17;                 // multiplier taken in two halves
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'(FRAME_MUL) << RECIP_SHIFT) + 64'(FRAME_DIV) - 64'd1) / 64'(FRAME_DIV));
  localparam int unsigned MPROD_W = MS_W + RECIP_LO_W;      // one partial product
  localparam int unsigned MSUM_W  = MPROD_W + RECIP_LO_W;   // full ms * RECIP

endpackage

`default_nettype wire

FILE: src/voice_allocator_with_expiry.sv
// Top level: voice allocator with expiry, sequencer around one shared divider.
//
// Usage: drive a request on the input ports and raise start while busy is low;
// the request is taken at that clock edge. Each request gives exactly one
// result beat, shown for one cycle with done_o high; the receiver cannot stall
// and must take it then.
// Path from accept to the done_o cycle:
//   stop, query, failed play, play with invalid header: answered from idle.
//   play with zero rate: a multiply stage and a load stage.
//   tick: a scan of all voices, one voice compared per cycle.
//   play with valid header: a multiply and a load stage, then one pass
//   through the one-bit-per-cycle restoring divider (samples*1000 by
//   rate), then two reciprocal partial products plus a sum stage.
// busy is high while the sequencer is out of idle, up to the result beat;
// requests answered from idle never raise it. A new request can be taken
// in the cycle that shows the result.
// Reset clears the frame counter, all busy flags and the sequencer; handle,
// start and duration stores are written on play and need no clearing.
`default_nettype none

module voice_allocator_with_expiry #(
  parameter int unsigned VOICES     = vae_pkg::VOICES_DEF,
  parameter int unsigned SLOT_LIMIT = vae_pkg::SLOT_LIMIT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  sound_slot_i,
  input  wire logic        slot_loaded_i,
  input  wire logic        header_valid_i,
  input  wire logic [15:0] pitch_i,
  input  wire logic [23:0] sample_count_i,
  input  wire logic [7:0]  hw_voice_i,
  input  wire logic        hw_voice_ok_i,
  input  wire logic [4:0]  voice_index_i,
  input  wire logic [15:0] streaming_mask_i,
  output logic             done_o,
  output logic             ok_o,
  output logic [3:0]       voice_out_o,
  output logic [7:0]       hw_voice_out_o,
  output logic             silence_o,
  output logic [15:0]      expired_mask_o
);

  localparam int unsigned VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned FRAME_W = vae_pkg::FRAME_W;
  localparam int unsigned RATE_W  = vae_pkg::RATE_W;
  localparam int unsigned DIV_W   = vae_pkg::DIV_W;
  localparam int unsigned DCNT_W  = vae_pkg::DCNT_W;
  localparam int unsigned PROD_W  = vae_pkg::PROD_W;
  localparam int unsigned NUM_W   = vae_pkg::NUM_W;
  localparam int unsigned MS_W    = vae_pkg::MS_W;
  localparam int unsigned RECIP_W = vae_pkg::RECIP_W;
  localparam int unsigned RECIP_LO_W = vae_pkg::RECIP_LO_W;
  localparam int unsigned MPROD_W = vae_pkg::MPROD_W;
  localparam int unsigned MSUM_W  = vae_pkg::MSUM_W;
  localparam logic [RECIP_W-1:0] RECIP = vae_pkg::RECIP;
  localparam logic [FRAME_W-1:0] DUR_MAX_C = vae_pkg::DUR_MAX;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RATE = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV1 = 3'd4;
  localparam logic [2:0] ST_MULH = 3'd5;
  localparam logic [2:0] ST_MULL = 3'd6;
  localparam logic [2:0] ST_SUM  = 3'd7;

  // Control state
  logic [2:0]          state_q, state_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [VOICES-1:0]   busy_q, busy_d;
  logic [VW-1:0]       found_q, found_d;
  logic [VW-1:0]       cnt_q, cnt_d;
  logic [VOICES-1:0]   smask_q, smask_d;
  logic [VOICES-1:0]   emask_q, emask_d;
  logic                done_q, done_d;
  logic                ok_q, ok_d;
  logic [3:0]          vout_q, vout_d;
  logic [7:0]          hout_q, hout_d;
  logic                sil_q, sil_d;

  // Datapath registers
  logic [15:0]         pitch_q, pitch_d;
  logic [23:0]         samples_q, samples_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [RATE_W-1:0]   div_rem_q, div_rem_d;
  logic [RATE_W-1:0]   div_den_q, div_den_d;
  logic [DIV_W-1:0]    div_quo_q, div_quo_d;
  logic [DCNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [MPROD_W-1:0]  prod_hi_q, prod_hi_d;
  logic [MPROD_W-1:0]  prod_lo_q, prod_lo_d;

  // Per-voice stores, written on play only
  logic [7:0]          handle_q [VOICES];
  logic [FRAME_W-1:0]  start_q  [VOICES];
  logic [FRAME_W-1:0]  dur_q    [VOICES];

  // Combinational helpers
  logic                accept;
  logic                free_any;
  logic [VW-1:0]       free_idx;
  logic                play_ok;
  logic                vidx_ok;
  logic [VW-1:0]       vidx;
  logic                hit;
  logic                dur_we;
  logic [VW-1:0]       dur_idx;
  logic [FRAME_W-1:0]  dur_wdata;
  logic [FRAME_W-1:0]  elapsed;
  logic                expire_hit;
  logic [PROD_W-1:0]   rate_prod;
  logic [NUM_W-1:0]    num_prod;
  logic [RATE_W:0]     step_shift;
  logic                step_ge;
  logic [RATE_W-1:0]   step_rem;
  logic [DIV_W-1:0]    step_quo;
  logic [MS_W-1:0]     ms;
  logic [RECIP_LO_W-1:0] mul_k;
  logic [MPROD_W-1:0]  mul_res;
  logic [MSUM_W-1:0]   scaled;
  logic [FRAME_W:0]    frames_sum;

  assign accept = start && (state_q == ST_IDLE);

  // Find the lowest free voice
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int c = VOICES - 1; c >= 0; c--) begin
      if (!busy_q[c]) begin
        free_any = 1'b1;
        free_idx = VW'(c);
      end
    end
  end

  assign play_ok = (9'(sound_slot_i) < 9'(SLOT_LIMIT)) && slot_loaded_i && free_any &&
                   hw_voice_ok_i;
  assign vidx_ok = (6'(voice_index_i) < 6'(VOICES));
  assign vidx    = voice_index_i[VW-1:0];
  assign hit     = vidx_ok && busy_q[vidx];

  // Expiry compare for the voice under scan
  assign elapsed    = frame_q - start_q[cnt_q];
  assign expire_hit = busy_q[cnt_q] && !smask_q[cnt_q] && (elapsed >= dur_q[cnt_q]);

  // Multiplies, one per stage
  assign rate_prod = PROD_W'(pitch_q) * PROD_W'(vae_pkg::BASE_RATE);
  assign num_prod  = NUM_W'(samples_q) * NUM_W'(vae_pkg::MS_PER_S);

  // Shared divider: one restoring step per cycle
  assign step_shift = {div_rem_q, div_quo_q[DIV_W-1]};
  assign step_ge    = (step_shift >= {1'b0, div_den_q});
  assign step_rem   = step_ge ? RATE_W'(step_shift - {1'b0, div_den_q})
                              : step_shift[RATE_W-1:0];
  assign step_quo   = {div_quo_q[DIV_W-2:0], step_ge};

  // Scale ms to frames by the reciprocal, upper half then lower half
  assign ms         = div_quo_q[MS_W-1:0];
  assign mul_k      = (state_q == ST_MULH) ? RECIP[RECIP_W-1:RECIP_LO_W]
                                           : RECIP[RECIP_LO_W-1:0];
  assign mul_res    = MPROD_W'(ms) * MPROD_W'(mul_k);
  assign scaled     = {prod_hi_q, {RECIP_LO_W{1'b0}}} + MSUM_W'(prod_lo_q);
  assign frames_sum = (FRAME_W+1)'(scaled[MSUM_W-1:vae_pkg::RECIP_SHIFT]) +
                      (FRAME_W+1)'(vae_pkg::EXTRA_FRAMES);

  // Sequencer and next state
  always_comb begin
    state_d   = state_q;
    frame_d   = frame_q;
    busy_d    = busy_q;
    found_d   = found_q;
    cnt_d     = cnt_q;
    smask_d   = smask_q;
    emask_d   = emask_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    vout_d    = vout_q;
    hout_d    = hout_q;
    sil_d     = sil_q;
    pitch_d   = pitch_q;
    samples_d = samples_q;
    rate_d    = rate_q;
    div_rem_d = div_rem_q;
    div_den_d = div_den_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    prod_hi_d = prod_hi_q;
    prod_lo_d = prod_lo_q;
    dur_we    = 1'b0;
    dur_idx   = found_q;
    dur_wdata = DUR_MAX_C;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          emask_d = '0;
          ok_d    = 1'b0;
          vout_d  = '0;
          hout_d  = '0;
          sil_d   = 1'b0;
          case (vae_pkg::func_e'(func_i))
            vae_pkg::FUNC_TICK: begin
              frame_d = frame_q + 1'b1;
              smask_d = streaming_mask_i[VOICES-1:0];
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            vae_pkg::FUNC_PLAY: begin
              if (play_ok) begin
                busy_d[free_idx] = 1'b1;
                found_d = free_idx;
                ok_d    = 1'b1;
                vout_d  = 4'(free_idx);
                if (header_valid_i) begin
                  pitch_d   = pitch_i;
                  samples_d = sample_count_i;
                  state_d   = ST_RATE;
                end else begin
                  dur_we    = 1'b1;
                  dur_idx   = free_idx;
                  dur_wdata = FRAME_W'(vae_pkg::DEFAULT_FRAMES);
                  done_d    = 1'b1;
                end
              end else begin
                done_d = 1'b1;
              end
            end
            vae_pkg::FUNC_STOP: begin
              if (hit) begin
                ok_d         = 1'b1;
                sil_d        = 1'b1;
                hout_d       = handle_q[vidx];
                busy_d[vidx] = 1'b0;
              end
              done_d = 1'b1;
            end
            default: begin
              if (hit) begin
                ok_d   = 1'b1;
                hout_d = handle_q[vidx];
              end
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (expire_hit) begin
          busy_d[cnt_q]  = 1'b0;
          emask_d[cnt_q] = 1'b1;
        end
        if (cnt_q == VW'(VOICES - 1)) begin
          ok_d    = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RATE: begin
        rate_d  = rate_prod[PROD_W-1:vae_pkg::PITCH_SHIFT];
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (rate_q == '0) begin
          // zero rate saturates the duration
          dur_we    = 1'b1;
          dur_wdata = DUR_MAX_C;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          div_quo_d = DIV_W'(num_prod);
          div_den_d = rate_q;
          div_rem_d = '0;
          div_cnt_d = DCNT_W'(DIV_W - 1);
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        div_rem_d = step_rem;
        div_quo_d = step_quo;
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          // hold ms in the quotient for the scaling stages
          state_d = ST_MULH;
        end
      end
      ST_MULH: begin
        prod_hi_d = mul_res;
        state_d   = ST_MULL;
      end
      ST_MULL: begin
        prod_lo_d = mul_res;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        dur_we    = 1'b1;
        dur_wdata = (frames_sum > (FRAME_W+1)'(DUR_MAX_C)) ? DUR_MAX_C
                                                             : frames_sum[FRAME_W-1:0];
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      frame_q <= '0;
      busy_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    cnt_q     <= cnt_d;
    smask_q   <= smask_d;
    emask_q   <= emask_d;
    ok_q      <= ok_d;
    vout_q    <= vout_d;
    hout_q    <= hout_d;
    sil_q     <= sil_d;
    pitch_q   <= pitch_d;
    samples_q <= samples_d;
    rate_q    <= rate_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_quo_q <= div_quo_d;
    div_cnt_q <= div_cnt_d;
    prod_hi_q <= prod_hi_d;
    prod_lo_q <= prod_lo_d;
  end

  // Per-voice stores
  always_ff @(posedge clk_i) begin
    if (accept && (vae_pkg::func_e'(func_i) == vae_pkg::FUNC_PLAY) && play_ok) begin
      handle_q[free_idx] <= hw_voice_i;
      start_q[free_idx]  <= frame_q;
    end
    if (dur_we) begin
      dur_q[dur_idx] <= dur_wdata;
    end
  end

  // Drive outputs
  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign voice_out_o    = vout_q;
  assign hw_voice_out_o = hout_q;
  assign silence_o      = sil_q;
  assign expired_mask_o = 16'(emask_q);

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while sequencer still active");

  a_accept_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request produced neither work nor result");

  a_silence_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && silence_o) |-> ok_o)
    else $error("silence reported on a failed stop");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV1) |-> (div_rem_q < div_den_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: tb/voice_allocator_with_expiry_tb.sv
// Self-checking testbench for the voice allocator with expiry.
`timescale 1ns / 1ps

module voice_allocator_with_expiry_tb;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_REQS = 1625;

  typedef struct packed {
    vae_pkg::func_e func;
    logic [7:0]  sound_slot;
    logic        slot_loaded;
    logic        header_valid;
    logic [15:0] pitch;
    logic [23:0] sample_count;
    logic [7:0]  hw_voice;
    logic        hw_voice_ok;
    logic [4:0]  voice_index;
    logic [15:0] streaming_mask;
  } voice_req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  voice_out;
    logic [7:0]  hw_voice_out;
    logic        silence;
    logic [15:0] expired_mask;
  } voice_rsp_t;

  localparam int unsigned REQ_W = $bits(voice_req_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start_q = 1'b0;
  voice_req_t req_q = '0;
  logic busy;
  logic done;
  logic ok;
  logic [3:0] voice_out;
  logic [7:0] hw_voice_out;
  logic silence;
  logic [15:0] expired_mask;

  voice_req_t pending_req[$];
  voice_rsp_t expected_rsp[$];
  int unsigned issued = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  logic hold_start;

  // Shadow copy of the voice table
  logic [31:0] frame_count = '0;
  logic [15:0] voice_live = '0;
  logic [7:0]  live_handle [vae_pkg::VOICES_DEF];
  logic [31:0] live_start [vae_pkg::VOICES_DEF];
  logic [31:0] live_frames [vae_pkg::VOICES_DEF];

  voice_allocator_with_expiry i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start_q),
    .busy             (busy),
    .func_i           (req_q.func),
    .sound_slot_i     (req_q.sound_slot),
    .slot_loaded_i    (req_q.slot_loaded),
    .header_valid_i   (req_q.header_valid),
    .pitch_i          (req_q.pitch),
    .sample_count_i   (req_q.sample_count),
    .hw_voice_i       (req_q.hw_voice),
    .hw_voice_ok_i    (req_q.hw_voice_ok),
    .voice_index_i    (req_q.voice_index),
    .streaming_mask_i (req_q.streaming_mask),
    .done_o           (done),
    .ok_o             (ok),
    .voice_out_o      (voice_out),
    .hw_voice_out_o   (hw_voice_out),
    .silence_o        (silence),
    .expired_mask_o   (expired_mask)
  );

  always #5 clk = ~clk;

  // Playing time in frames from the sample header, floored and saturated
  function automatic logic [31:0] frames_for_sound(logic valid, logic [15:0] pitch,
                                                    logic [23:0] samples);
    logic [63:0] rate;
    logic [63:0] ms;
    logic [63:0] frames;
    if (!valid) return vae_pkg::DEFAULT_FRAMES;
    rate = (64'(pitch) * 64'(vae_pkg::BASE_RATE)) >> vae_pkg::PITCH_SHIFT;
    if (rate == 64'd0) return vae_pkg::DUR_MAX;
    ms = (64'(samples) * 64'(vae_pkg::MS_PER_S)) / rate;
    frames = (ms * 64'(vae_pkg::FRAMES_PER_S)) / 64'(vae_pkg::MS_PER_S) +
             64'(vae_pkg::EXTRA_FRAMES);
    if (frames > 64'(vae_pkg::DUR_MAX)) return vae_pkg::DUR_MAX;
    return frames[31:0];
  endfunction

  // Apply one request to the shadow table and return the response it earns
  function automatic voice_rsp_t predict_response(voice_req_t r);
    voice_rsp_t rsp;
    int v;
    bit placed;
    rsp = '0;
    placed = 1'b0;
    case (r.func)
      vae_pkg::FUNC_TICK: begin
        frame_count = frame_count + 32'd1;
        rsp.ok = 1'b1;
        for (v = 0; v < vae_pkg::VOICES_DEF; v++) begin
          if (!r.streaming_mask[v] && voice_live[v] &&
              (frame_count - live_start[v]) >= live_frames[v]) begin
            voice_live[v] = 1'b0;
            rsp.expired_mask[v] = 1'b1;
          end
        end
      end
      vae_pkg::FUNC_PLAY: begin
        if (32'(r.sound_slot) < vae_pkg::SLOT_LIMIT_DEF && r.slot_loaded &&
            r.hw_voice_ok) begin
          for (v = 0; v < vae_pkg::VOICES_DEF; v++) begin
            if (!placed && !voice_live[v]) begin
              placed = 1'b1;
              voice_live[v] = 1'b1;
              live_handle[v] = r.hw_voice;
              live_start[v] = frame_count;
              live_frames[v] = frames_for_sound(r.header_valid, r.pitch, r.sample_count);
              rsp.ok = 1'b1;
              rsp.voice_out = v[3:0];
            end
          end
        end
      end
      vae_pkg::FUNC_STOP: begin
        if (32'(r.voice_index) < vae_pkg::VOICES_DEF && voice_live[r.voice_index[3:0]]) begin
          rsp.ok = 1'b1;
          rsp.silence = 1'b1;
          rsp.hw_voice_out = live_handle[r.voice_index[3:0]];
          voice_live[r.voice_index[3:0]] = 1'b0;
        end
      end
      default: begin
        if (32'(r.voice_index) < vae_pkg::VOICES_DEF && voice_live[r.voice_index[3:0]]) begin
          rsp.ok = 1'b1;
          rsp.hw_voice_out = live_handle[r.voice_index[3:0]];
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic voice_req_t play_req(logic loaded, logic valid, logic [15:0] pitch,
                                          logic [23:0] samples, logic [7:0] hw,
                                          logic hw_ok);
    voice_req_t r;
    r = '0;
    r.func = vae_pkg::FUNC_PLAY;
    r.sound_slot = 8'($urandom_range(255));
    r.slot_loaded = loaded;
    r.header_valid = valid;
    r.pitch = pitch;
    r.sample_count = samples;
    r.hw_voice = hw;
    r.hw_voice_ok = hw_ok;
    return r;
  endfunction

  function automatic voice_req_t index_req(vae_pkg::func_e f, logic [4:0] idx,
                                           logic [15:0] smask);
    voice_req_t r;
    r = '0;
    r.func = f;
    r.voice_index = idx;
    r.streaming_mask = smask;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: record the accepted beat, then present the next request or idle
  always @(posedge clk) begin
    if (rst_n) begin
      hold_start = start_q;
      if (start_q && !busy) begin
        expected_rsp.push_back(predict_response(req_q));
        hold_start = 1'b0;
      end
      if (!hold_start && pending_req.size() != 0 &&
          ($urandom_range(99) >= 38 || (issued >= 700 && issued < 1000))) begin
        req_q <= pending_req.pop_front();
        issued++;
        hold_start = 1'b1;
      end
      start_q <= hold_start;
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, actual ok=%0b voice=%0h",
                 $time, ok, voice_out);
        errors++;
      end else begin
        voice_rsp_t want;
        want = expected_rsp.pop_front();
        check_field("ok", 32'(want.ok), 32'(ok));
        check_field("voice_out", 32'(want.voice_out), 32'(voice_out));
        check_field("hw_voice_out", 32'(want.hw_voice_out), 32'(hw_voice_out));
        check_field("silence", 32'(want.silence), 32'(silence));
        check_field("expired_mask", 32'(want.expired_mask), 32'(expired_mask));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start_q && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    voice_req_t r;
    int unsigned roll;
    int n;

    // Directed: empty table, every failure reason, duration corners, full table
    pending_req.push_back(index_req(vae_pkg::FUNC_TICK, 5'd0, 16'h0000));
    pending_req.push_back(index_req(vae_pkg::FUNC_QUERY, 5'd31, 16'h0000));
    pending_req.push_back(play_req(1'b1, 1'b0, 16'h0000, 24'h000000, 8'hFF, 1'b1));
    pending_req.push_back(play_req(1'b0, 1'b1, 16'h1000, 24'h000100, 8'h11, 1'b1));
    pending_req.push_back(play_req(1'b1, 1'b1, 16'h1000, 24'h000100, 8'h22, 1'b0));
    pending_req.push_back(play_req(1'b1, 1'b1, 16'h0000, 24'h001000, 8'h00, 1'b1));
    pending_req.push_back(play_req(1'b1, 1'b1, 16'hFFFF, 24'hFFFFFF, 8'hA5, 1'b1));
    pending_req.push_back(play_req(1'b1, 1'b1, 16'h0001, 24'h000000, 8'h5A, 1'b1));
    pending_req.push_back(play_req(1'b1, 1'b1, 16'd4096, 24'd22050, 8'h3C, 1'b1));
    pending_req.push_back(play_req(1'b1, 1'b1, 16'h0001, 24'hFFFFFF, 8'h77, 1'b1));
    pending_req.push_back(index_req(vae_pkg::FUNC_QUERY, 5'd2, 16'h0000));
    pending_req.push_back(index_req(vae_pkg::FUNC_STOP, 5'd1, 16'h0000));
    pending_req.push_back(index_req(vae_pkg::FUNC_STOP, 5'd1, 16'h0000));
    pending_req.push_back(index_req(vae_pkg::FUNC_TICK, 5'd0, 16'hFFFF));
    for (n = 0; n < 13; n++) begin
      pending_req.push_back(play_req(1'b1, 1'b0, 16'h0000, 24'h0, 8'(n * 19), 1'b1));
    end

    // Random: mostly well-formed plays with short lives so ticks free them
    for (n = 0; n < RANDOM_REQS; n++) begin
      r = voice_req_t'(REQ_W'({$urandom, $urandom, $urandom}));
      roll = $urandom_range(99);
      if (roll < 45) begin
        r.func = vae_pkg::FUNC_TICK;
        if ($urandom_range(99) < 75) r.streaming_mask = '0;
      end else if (roll < 70) begin
        r.func = vae_pkg::FUNC_PLAY;
        r.slot_loaded = ($urandom_range(9) != 0);
        r.hw_voice_ok = ($urandom_range(9) != 0);
        if ($urandom_range(99) < 70) begin
          r.pitch = 16'($urandom_range(16'hFFFF, 16'h4000));
          r.sample_count = 24'($urandom_range(200000));
        end
      end else begin
        r.func = (roll < 85) ? vae_pkg::FUNC_STOP : vae_pkg::FUNC_QUERY;
        if ($urandom_range(99) < 85) r.voice_index = 5'($urandom_range(15));
      end
      pending_req.push_back(r);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all requests taken, all results seen, then a quiet tail
    while (pending_req.size() != 0 || start_q) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
